/* sv/psa_pkg.sv */
// ----------------------------------------------------------------------------
// psa_pkg: shared types and constants for the pointer speed/accel block
// Word layouts of both channels, datapath widths and unit control struct.
// ----------------------------------------------------------------------------
package psa_pkg;

  // Input word: one pointer sample
  typedef struct packed {
    logic        [15:0] event_code;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic        [31:0] time_ms;
  } psa_in_t;

  // Output word: one speed/accel result
  typedef struct packed {
    logic        [31:0] speed;
    logic signed [31:0] accel;
    logic               is_click;
    logic               is_first;
  } psa_out_t;

  // Start/advance pair driven by the sequencer into each serial unit
  typedef struct packed {
    logic load;
    logic step;
  } psa_ctl_t;

  localparam logic [15:0] CLICK_CODE_RST = 16'd513;

  localparam int MAG_W   = 16;  // |dx|, |dy|
  localparam int SUMSQ_W = 34;  // dx^2 + dy^2
  localparam int ROOT_W  = 33;  // floor(sqrt(sum * 2^32))
  localparam int DIV_W   = 32;  // divisor and remainder
  localparam int QUOT_W  = 33;  // quotient, top bit flags overflow
  localparam int CNT_W   = 6;

  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(MAG_W - 1);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W);
  localparam logic [CNT_W-1:0] ACC_LAST  = CNT_W'(DIV_W - 1);

endpackage

/* sv/psa_sqmac.sv */
// ----------------------------------------------------------------------------
// psa_sqmac: bit-serial sum of two squares
// Forms |dx|^2 + |dy|^2 by shift-and-add, one multiplier bit per step.
// ----------------------------------------------------------------------------
module psa_sqmac (
  input  logic                      clk,
  input  psa_pkg::psa_ctl_t         ctl,
  input  logic [psa_pkg::MAG_W-1:0] mag_x,
  input  logic [psa_pkg::MAG_W-1:0] mag_y,
  output logic [psa_pkg::SUMSQ_W-1:0] sum
);
  import psa_pkg::*;

  logic [MAG_W-1:0]     mplx_r, mplx_nxt, mply_r, mply_nxt;
  logic [2*MAG_W-1:0]   mcdx_r, mcdx_nxt, mcdy_r, mcdy_nxt;
  logic [SUMSQ_W-1:0]   acc_r, acc_nxt;
  logic [SUMSQ_W-1:0]   add_x, add_y;

  always_comb begin
    add_x    = mplx_r[0] ? SUMSQ_W'(mcdx_r) : '0;
    add_y    = mply_r[0] ? SUMSQ_W'(mcdy_r) : '0;
    mplx_nxt = mplx_r;
    mply_nxt = mply_r;
    mcdx_nxt = mcdx_r;
    mcdy_nxt = mcdy_r;
    acc_nxt  = acc_r;
    if (ctl.load) begin
      mplx_nxt = mag_x;
      mply_nxt = mag_y;
      mcdx_nxt = (2*MAG_W)'(mag_x);
      mcdy_nxt = (2*MAG_W)'(mag_y);
      acc_nxt  = '0;
    end else if (ctl.step) begin
      acc_nxt  = acc_r + add_x + add_y;
      mplx_nxt = mplx_r >> 1;
      mply_nxt = mply_r >> 1;
      mcdx_nxt = mcdx_r << 1;
      mcdy_nxt = mcdy_r << 1;
    end
  end

  always_ff @(posedge clk) begin
    mplx_r <= mplx_nxt;
    mply_r <= mply_nxt;
    mcdx_r <= mcdx_nxt;
    mcdy_r <= mcdy_nxt;
    acc_r  <= acc_nxt;
  end

  assign sum = acc_r;

endmodule

/* sv/psa_sqrt.sv */
// ----------------------------------------------------------------------------
// psa_sqrt: digit-by-digit integer square root
// One bit pair in, one root bit out per step; radicand is sum * 2^32.
// ----------------------------------------------------------------------------
module psa_sqrt (
  input  logic                        clk,
  input  psa_pkg::psa_ctl_t           ctl,
  input  logic [psa_pkg::SUMSQ_W-1:0] radicand,
  output logic                        root_bit
);
  import psa_pkg::*;

  localparam int REM_W = SUMSQ_W;
  localparam int EXT_W = REM_W + 2;

  logic [SUMSQ_W-1:0] vsh_r, vsh_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [EXT_W-1:0]   rem_sh, trial, diff;
  logic               ge;

  always_comb begin
    rem_sh   = {rem_r, vsh_r[SUMSQ_W-1 -: 2]};
    trial    = EXT_W'({root_r, 2'b01});
    diff     = rem_sh - trial;
    ge       = (rem_sh >= trial);
    vsh_nxt  = vsh_r;
    root_nxt = root_r;
    rem_nxt  = rem_r;
    if (ctl.load) begin
      vsh_nxt  = radicand;
      root_nxt = '0;
      rem_nxt  = '0;
    end else if (ctl.step) begin
      // zero pairs shift in once the radicand is spent (the 2^32 scale)
      vsh_nxt  = {vsh_r[SUMSQ_W-3:0], 2'b00};
      root_nxt = {root_r[ROOT_W-2:0], ge};
      rem_nxt  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    vsh_r  <= vsh_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
  end

  // newest root bit, taken by the divider in the following cycle
  assign root_bit = root_r[0];

endmodule

/* sv/psa_div.sv */
// ----------------------------------------------------------------------------
// psa_div: bit-serial restoring divider
// Dividend arrives MSB first, one bit per step; quotient shifts in LSB side.
// ----------------------------------------------------------------------------
module psa_div (
  input  logic                       clk,
  input  psa_pkg::psa_ctl_t          ctl,
  input  logic                       dvd_bit,
  input  logic [psa_pkg::DIV_W-1:0]  divisor,
  output logic [psa_pkg::QUOT_W-1:0] quot
);
  import psa_pkg::*;

  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [DIV_W:0]    rem_sh, diff;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_bit};
    diff    = rem_sh - {1'b0, divisor};
    ge      = (rem_sh >= {1'b0, divisor});
    rem_nxt = rem_r;
    q_nxt   = q_r;
    if (ctl.load) begin
      rem_nxt = '0;
      q_nxt   = '0;
    end else if (ctl.step) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      q_nxt   = {q_r[QUOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign quot = q_r;

endmodule

/* sv/pointer_speed_accel_top.sv */
// ----------------------------------------------------------------------------
// pointer_speed_accel_top: pointer speed and acceleration by finite difference
// Serial datapath turning timestamped pointer samples into Q16.16 speed/accel.
// ----------------------------------------------------------------------------
// Use:
//   in_*  : one sample word (event code, x, y, ms timestamp), valid/ready.
//   out_* : one result word (speed, accel, click flag, first flag).
//   cfg_* : write of click_code; always ready, write only while idle.
// Sequence:
//   A normal sample runs from acceptance through the shift-add squares, a
//   root-unit load, the root feeding the speed division bit-serially, the
//   speed difference, the accel division and the register of the result
//   word. One sample in flight at a time: in_ready stays low until the
//   write-back. The first sample after reset skips the arithmetic and goes
//   straight to the write-back of its word. A sample repeating the previous
//   timestamp is dropped with no word and in_ready stays high.
// Reset (rst_n low, synchronous): no history, click_code back to 513,
//   output empty.
// Stall: the output word sits in its own register; the next sample is still
//   taken and worked on, and only the final write-back waits for out_ready.
// ----------------------------------------------------------------------------
module pointer_speed_accel_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  psa_pkg::psa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output psa_pkg::psa_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [15:0]       cfg_data
);
  import psa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,    // shift-add squares
    S_RLD,   // load root unit, clear divider
    S_ROOT,  // root bits stream into speed division
    S_DIFF,  // saturate speed, form |speed - previous|
    S_ACC,   // accel division
    S_FIN    // write result word, commit history
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // history
  logic                 have_prev_r, have_prev_nxt;
  logic signed [15:0]   prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [31:0]          prev_t_r, prev_t_nxt;
  logic [31:0]          prev_speed_r, prev_speed_nxt;
  logic [15:0]          click_code_r, click_code_nxt;

  // current sample
  logic signed [15:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [31:0]          cur_t_r, cur_t_nxt;
  logic [31:0]          dt_r, dt_nxt;
  logic                 click_r, click_nxt, first_r, first_nxt;
  logic [31:0]          speed_r, speed_nxt;
  logic                 neg_r, neg_nxt;
  logic [31:0]          dvd_r, dvd_nxt;

  logic                 out_valid_r, out_valid_nxt;
  psa_out_t             out_data_r, out_data_nxt;

  // unit hookup
  psa_ctl_t             sq_ctl, rt_ctl, dv_ctl;
  logic [MAG_W-1:0]     mag_x, mag_y;
  logic [SUMSQ_W-1:0]   sumsq;
  logic                 root_bit, dv_bit;
  logic [QUOT_W-1:0]    quot;

  // combinational helpers
  logic                 in_fire;
  logic [31:0]          dt_in;
  logic [16:0]          dx_a, dx_b, dy_a, dy_b;
  logic [31:0]          speed_sat, up_diff, dn_diff, mag_q, accel_val;
  logic                 out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // dt modulo 2^32; |dx|, |dy| from two opposite subtractions
  assign dt_in = in_data.time_ms - prev_t_r;
  assign dx_a  = {in_data.x_pos[15], in_data.x_pos} - {prev_x_r[15], prev_x_r};
  assign dx_b  = {prev_x_r[15], prev_x_r} - {in_data.x_pos[15], in_data.x_pos};
  assign dy_a  = {in_data.y_pos[15], in_data.y_pos} - {prev_y_r[15], prev_y_r};
  assign dy_b  = {prev_y_r[15], prev_y_r} - {in_data.y_pos[15], in_data.y_pos};
  assign mag_x = dx_a[16] ? dx_b[MAG_W-1:0] : dx_a[MAG_W-1:0];
  assign mag_y = dy_a[16] ? dy_b[MAG_W-1:0] : dy_a[MAG_W-1:0];

  // speed quotient: top bit set means it overflowed 32 bits
  assign speed_sat = quot[QUOT_W-1] ? '1 : quot[31:0];
  assign up_diff   = speed_sat - prev_speed_r;
  assign dn_diff   = prev_speed_r - speed_sat;

  // accel: zero for a first sample; else clamp magnitude to the signed range, then apply sign
  assign mag_q = quot[31:0];
  always_comb begin
    if (first_r) begin
      accel_val = '0;
    end else if (neg_r) begin
      accel_val = mag_q[31] ? 32'h8000_0000 : (32'd0 - mag_q);
    end else begin
      accel_val = mag_q[31] ? 32'h7FFF_FFFF : mag_q;
    end
  end

  // unit control
  always_comb begin
    sq_ctl.load = in_fire && have_prev_r && (dt_in != '0);
    sq_ctl.step = (state_r == S_SQ);
    rt_ctl.load = (state_r == S_RLD);
    rt_ctl.step = (state_r == S_ROOT) && (cnt_r != ROOT_LAST);
    dv_ctl.load = (state_r == S_RLD) || (state_r == S_DIFF);
    dv_ctl.step = ((state_r == S_ROOT) && (cnt_r != '0)) || (state_r == S_ACC);
    dv_bit      = (state_r == S_ACC) ? dvd_r[31] : root_bit;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    have_prev_nxt  = have_prev_r;
    prev_x_nxt     = prev_x_r;
    prev_y_nxt     = prev_y_r;
    prev_t_nxt     = prev_t_r;
    prev_speed_nxt = prev_speed_r;
    click_code_nxt = click_code_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    cur_t_nxt      = cur_t_r;
    dt_nxt         = dt_r;
    click_nxt      = click_r;
    first_nxt      = first_r;
    speed_nxt      = speed_r;
    neg_nxt        = neg_r;
    dvd_nxt        = dvd_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (cfg_valid && cfg_ready) begin
      click_code_nxt = cfg_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cur_x_nxt = in_data.x_pos;
          cur_y_nxt = in_data.y_pos;
          cur_t_nxt = in_data.time_ms;
          click_nxt = (in_data.event_code == click_code_r);
          dt_nxt    = dt_in;
          cnt_nxt   = '0;
          if (!have_prev_r) begin
            first_nxt = 1'b1;
            speed_nxt = '0;
            state_nxt = S_FIN;
          end else if (dt_in != '0) begin
            first_nxt = 1'b0;
            state_nxt = S_SQ;
          end
          // repeated timestamp: dropped, stay idle
        end
      end
      S_SQ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_RLD;
        end
      end
      S_RLD: begin
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ROOT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: begin
        speed_nxt = speed_sat;
        neg_nxt   = (speed_sat < prev_speed_r);
        dvd_nxt   = (speed_sat < prev_speed_r) ? dn_diff : up_diff;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cnt_nxt = cnt_r + 1'b1;
        dvd_nxt = {dvd_r[30:0], 1'b0};
        if (cnt_r == ACC_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.speed    = speed_r;
          out_data_nxt.accel    = accel_val;
          out_data_nxt.is_click = click_r;
          out_data_nxt.is_first = first_r;
          have_prev_nxt         = 1'b1;
          prev_x_nxt            = cur_x_r;
          prev_y_nxt            = cur_y_r;
          prev_t_nxt            = cur_t_r;
          prev_speed_nxt        = speed_r;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      have_prev_r  <= 1'b0;
      prev_x_r     <= '0;
      prev_y_r     <= '0;
      prev_t_r     <= '0;
      prev_speed_r <= '0;
      click_code_r <= CLICK_CODE_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      have_prev_r  <= have_prev_nxt;
      prev_x_r     <= prev_x_nxt;
      prev_y_r     <= prev_y_nxt;
      prev_t_r     <= prev_t_nxt;
      prev_speed_r <= prev_speed_nxt;
      click_code_r <= click_code_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    cur_t_r    <= cur_t_nxt;
    dt_r       <= dt_nxt;
    click_r    <= click_nxt;
    first_r    <= first_nxt;
    speed_r    <= speed_nxt;
    neg_r      <= neg_nxt;
    dvd_r      <= dvd_nxt;
    out_data_r <= out_data_nxt;
  end

  psa_sqmac u_sqmac (
    .clk   (clk),
    .ctl   (sq_ctl),
    .mag_x (mag_x),
    .mag_y (mag_y),
    .sum   (sumsq)
  );

  psa_sqrt u_sqrt (
    .clk      (clk),
    .ctl      (rt_ctl),
    .radicand (sumsq),
    .root_bit (root_bit)
  );

  psa_div u_div (
    .clk     (clk),
    .ctl     (dv_ctl),
    .dvd_bit (dv_bit),
    .divisor (dt_r),
    .quot    (quot)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
